[sv/button_debounce_short_long_press_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Clocked concurrent assertions with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH

// check prop at every rising edge of clk outside reset
`define BDSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check prop at every rising edge of clk, reset included
`define BDSL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/bdsl_pkg.sv]
// ---------------------------------------------------------------------------
// Button debounce package
// Types and constants shared by the debounce core and its wrapper.
// ---------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd40;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd800;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_ACTIVE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic             active_level;
  } bdsl_cfg_t;

endpackage

`default_nettype wire

[sv/bdsl_core.sv]
// ---------------------------------------------------------------------------
// Button debounce core
// Debounce state and press classification, one sample per step strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module bdsl_core
  import bdsl_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire bdsl_cfg_t        cfg,
  input  wire logic             raw_level,
  input  wire logic [NOW_W-1:0] now_ms,
  output ev_t                   press_event
);

  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] since_change, since_press;
  logic                 stable_level_r, stable_level_nxt;
  logic                 last_raw_r, last_raw_nxt;
  logic                 long_rep_r, long_rep_nxt;
  logic                 short_hit;

  assign now_w = TIME_BITS'(now_ms);

  always_comb begin
    last_raw_nxt     = raw_level;
    change_time_nxt  = (raw_level != last_raw_r) ? now_w : change_time_r;
    since_change     = now_w - change_time_nxt;
    stable_level_nxt = stable_level_r;
    press_time_nxt   = press_time_r;
    long_rep_nxt     = long_rep_r;
    short_hit        = 1'b0;
    press_event      = EV_NONE;
    since_press      = '0;
    if (since_change >= TIME_BITS'(cfg.debounce_time)) begin
      stable_level_nxt = raw_level;
      if (raw_level != stable_level_r) begin
        if (raw_level == cfg.active_level) begin
          press_time_nxt = now_w;
          long_rep_nxt   = 1'b0;
        end else if (!long_rep_r && (press_time_r != '0)) begin
          press_time_nxt = '0;
          short_hit      = 1'b1;
          press_event    = EV_SHORT;
        end
      end
      since_press = now_w - press_time_nxt;
      if (!short_hit && (stable_level_nxt == cfg.active_level) && !long_rep_nxt &&
          (since_press >= TIME_BITS'(cfg.long_press_time))) begin
        long_rep_nxt = 1'b1;
        press_event  = EV_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r <= 1'b1;
      last_raw_r     <= 1'b1;
      change_time_r  <= '0;
      press_time_r   <= '0;
      long_rep_r     <= 1'b0;
    end else if (step) begin
      stable_level_r <= stable_level_nxt;
      last_raw_r     <= last_raw_nxt;
      change_time_r  <= change_time_nxt;
      press_time_r   <= press_time_nxt;
      long_rep_r     <= long_rep_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/button_debounce_short_long_press.sv]
// ---------------------------------------------------------------------------
// Button debounce with short and long press detection
// Debounces timestamped pin samples and reports short and long presses.
// ---------------------------------------------------------------------------
// channel   direction  payload
// in_       slave      raw_level, now_ms
// out_      master     press_event
// cfg_      write      debounce_time, long_press_time, active_level
//
// A request goes through the input and output registers to its result; one per cycle
// while the output is not stalled. The core's per-step state update sets the rate.
// Reset (synchronous) empties both registers and restores the defaults.
// A stalled output holds its result; the input register still takes one more.
// ---------------------------------------------------------------------------
`default_nettype none

module button_debounce_short_long_press
  import bdsl_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // raw_level, now_ms[31:0], zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // press_event[1:0], zero pad
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  bdsl_cfg_t        cfg_r;
  logic             in_v_r;
  logic             raw_r;
  logic [NOW_W-1:0] now_r;
  logic             out_v_r;
  ev_t              ev_r;
  ev_t              ev_nxt;
  logic             adv;

  assign adv        = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, ev_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_RST;
      cfg_r.long_press_time <= LONG_RST;
      cfg_r.active_level    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DEBOUNCE: cfg_r.debounce_time   <= cfg_wdata;
        CFG_LONG:     cfg_r.long_press_time <= cfg_wdata;
        CFG_ACTIVE:   cfg_r.active_level    <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      raw_r <= in_tdata[0];
      now_r <= in_tdata[NOW_W:1];
    end
  end

  bdsl_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .cfg         (cfg_r),
    .raw_level   (raw_r),
    .now_ms      (now_r),
    .press_event (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/bdsl_checker.sv]
// ---------------------------------------------------------------------------
// Button debounce port checker
// Watches the top-level ports for flow and result encoding slips.
// ---------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_short_long_press_assert.svh"

module bdsl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  `BDSL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `BDSL_ASSERT(a_out_code, out_tvalid |-> (out_tdata[1:0] != 2'd3) && (out_tdata[7:2] == 6'd0), "bad result code")
  `BDSL_ASSERT(a_in_to_out, in_tvalid && in_tready |-> ##2 out_tvalid, "request produced no result")
  `BDSL_ASSERT(a_stall_src, !in_tready |-> out_tvalid, "input stalled without pending result")

endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
